// ----- rtl/core/eprm_pkg.sv -----
// Shared constants, register indexes and types for the echo ranging median block.
// Used by eprm_distance, eprm_median and echo_pulse_range_median5; depends on nothing.
package eprm_pkg;

    // window geometry
    localparam int WINDOW_LEN  = 5;
    localparam int SLOT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int RANK_W      = $clog2(WINDOW_LEN + 1);
    localparam int MEDIAN_RANK = WINDOW_LEN / 2;

    // field widths
    localparam int TIME_W = 16;
    localparam int DIST_W = 11;

    // distance scale: floor(diff * 17 / 1000) = floor(floor(diff * 17 / 8) / 125)
    localparam int SCALED_W    = TIME_W + 5;
    localparam int QUOT_W      = SCALED_W - 3;
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(((1 << RECIP_SHIFT) + 124) / 125);
    localparam int PROD_W      = QUOT_W + RECIP_W;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_RANGE_LIMIT    = 2'd0;
    localparam logic [1:0] REG_ALARM_DISTANCE = 2'd1;
    localparam logic [1:0] REG_ALARM_MUTE     = 2'd2;

    localparam logic [DIST_W-1:0] RANGE_LIMIT_RESET    = DIST_W'(75);
    localparam logic [DIST_W-1:0] ALARM_DISTANCE_RESET = DIST_W'(20);

    // one pulse measurement handed from the scaler to the window
    typedef struct packed {
        logic              is_end;
        logic              new_valid;
        logic [DIST_W-1:0] distance;
    } dist_t;

    // configuration register set
    typedef struct packed {
        logic [DIST_W-1:0] range_limit;
        logic [DIST_W-1:0] alarm_distance;
        logic              alarm_mute;
    } cfg_t;

endpackage

// ----- rtl/core/eprm_distance.sv -----
// Edge pairing and distance scaling: two pipeline stages between the input register
// and the median window. Depends on eprm_pkg.
module eprm_distance
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [eprm_pkg::TIME_W-1:0]   edge_in,
    output logic                          in_ready,
    output logic                          out_valid,
    output eprm_pkg::dist_t               out_dist,
    input  logic                          out_ready
);

    logic                            awaiting_reg, awaiting_next;
    logic [eprm_pkg::TIME_W-1:0]     start_reg, start_next;

    logic                            s2_valid_reg, s2_valid_next;
    logic                            s2_is_end_reg;
    logic                            s2_gt_reg;
    logic [eprm_pkg::SCALED_W-1:0]   s2_scaled_reg, s2_scaled_next;

    logic                            s3_valid_reg, s3_valid_next;
    eprm_pkg::dist_t                 s3_reg, s3_next;

    logic                            ready2, ready3, load2, load3;
    logic [eprm_pkg::TIME_W-1:0]     diff;
    logic [eprm_pkg::QUOT_W-1:0]     quot;
    logic [eprm_pkg::PROD_W-1:0]     prod;

    // stage handshakes
    assign ready3    = !s3_valid_reg || out_ready;
    assign ready2    = !s2_valid_reg || ready3;
    assign load2     = in_valid && ready2;
    assign load3     = s2_valid_reg && ready3;
    assign in_ready  = ready2;
    assign out_valid = s3_valid_reg;
    assign out_dist  = s3_reg;

    // pair edges and scale the difference by 17
    always_comb
    begin
        diff           = edge_in - start_reg;
        s2_scaled_next = {1'b0, diff, 4'b0000} + {5'b00000, diff};
        awaiting_next  = awaiting_reg;
        start_next     = start_reg;
        if (load2)
        begin
            awaiting_next = !awaiting_reg;
            if (!awaiting_reg)
            begin
                start_next = edge_in;
            end
        end
        s2_valid_next = load2 ? 1'b1 : (ready3 ? 1'b0 : s2_valid_reg);
    end

    // divide by 1000 through a reciprocal multiply
    always_comb
    begin
        quot               = s2_scaled_reg[eprm_pkg::SCALED_W-1:3];
        prod               = eprm_pkg::PROD_W'(quot) * eprm_pkg::PROD_W'(eprm_pkg::RECIP_125);
        s3_next.is_end     = s2_is_end_reg;
        s3_next.new_valid  = s2_is_end_reg && s2_gt_reg;
        s3_next.distance   = prod[eprm_pkg::RECIP_SHIFT +: eprm_pkg::DIST_W];
        s3_valid_next      = load3 ? 1'b1 : (out_ready ? 1'b0 : s3_valid_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            start_reg    <= '0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            start_reg    <= start_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_is_end_reg <= awaiting_reg;
            s2_gt_reg     <= edge_in > start_reg;
            s2_scaled_reg <= s2_scaled_next;
        end
        if (load3)
        begin
            s3_reg <= s3_next;
        end
    end

    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        load2 |=> awaiting_reg != $past(awaiting_reg))
        else $error("edge phase did not toggle on a transaction");

    a_start_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load2 |=> start_reg == $past(start_reg))
        else $error("start time changed without a transaction");

endmodule

// ----- rtl/core/eprm_median.sv -----
// Ring window of distances, rank-based median and the result register.
// Depends on eprm_pkg.
module eprm_median
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  eprm_pkg::dist_t               in_dist,
    output logic                          in_ready,
    input  eprm_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [eprm_pkg::DIST_W-1:0]   median_distance,
    output logic                          measurement_done,
    output logic                          sample_accepted,
    output logic [eprm_pkg::DIST_W-1:0]   latest_distance,
    output logic                          proximity_alarm
);

    logic [eprm_pkg::DIST_W-1:0]  win_reg [eprm_pkg::WINDOW_LEN];
    logic [eprm_pkg::DIST_W-1:0]  win_next [eprm_pkg::WINDOW_LEN];
    logic [eprm_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [eprm_pkg::DIST_W-1:0]  held_reg, held_next;
    logic [eprm_pkg::RANK_W-1:0]  rank [eprm_pkg::WINDOW_LEN];

    logic                         out_valid_reg, out_valid_next;
    logic [eprm_pkg::DIST_W-1:0]  median_reg, median_next;
    logic                         done_reg;
    logic                         accepted_reg, accept;
    logic [eprm_pkg::DIST_W-1:0]  latest_reg;
    logic                         alarm_reg, alarm_next;
    logic                         load;

    assign in_ready = !out_valid_reg || !out_stall;
    assign load     = in_valid && in_ready;

    // keep or replace the held distance, then test it against the range limit
    always_comb
    begin
        held_next = in_dist.new_valid ? in_dist.distance : held_reg;
        accept    = in_dist.is_end && (held_next < cfg.range_limit);
        slot_next = slot_reg;
        if (accept)
        begin
            if (slot_reg == eprm_pkg::SLOT_W'(eprm_pkg::WINDOW_LEN - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + eprm_pkg::SLOT_W'(1);
            end
        end
        for (int i = 0; i < eprm_pkg::WINDOW_LEN; i++)
        begin
            win_next[i] = (accept && slot_reg == eprm_pkg::SLOT_W'(i)) ? held_next : win_reg[i];
        end
    end

    // rank every entry, ties broken by position; the middle rank is the median
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < eprm_pkg::WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < eprm_pkg::WINDOW_LEN; j++)
            begin
                if (j != i && (win_next[j] < win_next[i] ||
                               (win_next[j] == win_next[i] && j < i)))
                begin
                    rank[i] = rank[i] + eprm_pkg::RANK_W'(1);
                end
            end
            if (rank[i] == eprm_pkg::RANK_W'(eprm_pkg::MEDIAN_RANK))
            begin
                median_next = median_next | win_next[i];
            end
        end
        alarm_next     = !cfg.alarm_mute && (median_next < cfg.alarm_distance);
        out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    // window state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < eprm_pkg::WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            slot_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                win_reg  <= win_next;
                slot_reg <= slot_next;
                held_reg <= held_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            median_reg   <= median_next;
            done_reg     <= in_dist.is_end;
            accepted_reg <= accept;
            latest_reg   <= held_next;
            alarm_reg    <= alarm_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign median_distance  = median_reg;
    assign measurement_done = done_reg;
    assign sample_accepted  = accepted_reg;
    assign latest_distance  = latest_reg;
    assign proximity_alarm  = alarm_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < (eprm_pkg::SLOT_W + 1)'(eprm_pkg::WINDOW_LEN))
        else $error("write slot outside the window");

    a_accept_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sample_accepted |-> measurement_done)
        else $error("sample taken on a start edge");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && !accept |=> slot_reg == $past(slot_reg))
        else $error("write slot moved without a sample");

    a_latest: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> latest_distance == held_reg)
        else $error("latest distance differs from held distance");

endmodule

// ----- rtl/core/echo_pulse_range_median5.sv -----
// Top level of the echo ranging median filter: input register, APB registers and
// the two processing blocks. Depends on eprm_pkg, eprm_distance and eprm_median.
// Path: input register, then the eprm_distance stages, then the eprm_median result register.
// Throughput: one transaction per cycle; while a finished result waits, three more
// transactions are taken into the stages ahead of it, then the input stalls until it drains.
// Reset: rst_n clears the window, phase, start time, held distance and write slot to zero
// and loads the registers with range limit 75, alarm distance 20, mute off.
module echo_pulse_range_median5
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eprm_pkg::ADDR_W-1:0]   paddr,
    input  logic [eprm_pkg::DATA_W-1:0]   pwdata,
    output logic [eprm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [eprm_pkg::TIME_W-1:0]   edge_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [eprm_pkg::DIST_W-1:0]   median_distance,
    output logic                          measurement_done,
    output logic                          sample_accepted,
    output logic [eprm_pkg::DIST_W-1:0]   latest_distance,
    output logic                          proximity_alarm
);

    eprm_pkg::cfg_t                  cfg_reg;
    logic                            cfg_write;
    logic                            s1_valid_reg, s1_valid_next;
    logic [eprm_pkg::TIME_W-1:0]     s1_edge_reg;
    logic                            s1_ready, dist_ready;
    logic                            dist_valid, med_ready;
    eprm_pkg::dist_t                 dist_item;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_limit    <= eprm_pkg::RANGE_LIMIT_RESET;
            cfg_reg.alarm_distance <= eprm_pkg::ALARM_DISTANCE_RESET;
            cfg_reg.alarm_mute     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                eprm_pkg::REG_RANGE_LIMIT:    cfg_reg.range_limit    <= pwdata[eprm_pkg::DIST_W-1:0];
                eprm_pkg::REG_ALARM_DISTANCE: cfg_reg.alarm_distance <= pwdata[eprm_pkg::DIST_W-1:0];
                eprm_pkg::REG_ALARM_MUTE:     cfg_reg.alarm_mute     <= pwdata[0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            eprm_pkg::REG_RANGE_LIMIT:
                prdata = eprm_pkg::DATA_W'(cfg_reg.range_limit);
            eprm_pkg::REG_ALARM_DISTANCE:
                prdata = eprm_pkg::DATA_W'(cfg_reg.alarm_distance);
            eprm_pkg::REG_ALARM_MUTE:
                prdata = eprm_pkg::DATA_W'(cfg_reg.alarm_mute);
            default:
                prdata = '0;
        endcase
    end

    // input register
    assign s1_ready      = !s1_valid_reg || dist_ready;
    assign in_stall      = !s1_ready;
    assign s1_valid_next = (in_valid && s1_ready) ? 1'b1 : (dist_ready ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_edge_reg <= edge_time;
        end
    end

    eprm_distance u_distance
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .edge_in   (s1_edge_reg),
        .in_ready  (dist_ready),
        .out_valid (dist_valid),
        .out_dist  (dist_item),
        .out_ready (med_ready)
    );

    eprm_median u_median
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (dist_valid),
        .in_dist          (dist_item),
        .in_ready         (med_ready),
        .cfg              (cfg_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .median_distance  (median_distance),
        .measurement_done (measurement_done),
        .sample_accepted  (sample_accepted),
        .latest_distance  (latest_distance),
        .proximity_alarm  (proximity_alarm)
    );

endmodule

// ----- dv/echo_pulse_range_median5_test.sv -----
// Self-checking testbench for echo_pulse_range_median5: APB register setup, directed and
// random echo edges, and a scoreboard fed by an in-bench ranging and median predictor.
// Depends on eprm_pkg and the echo_pulse_range_median5 RTL.
module echo_pulse_range_median5_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_EDGES = 120;
    localparam int NUM_ROWS    = 24;

    // one result transaction
    typedef struct packed {
        logic [eprm_pkg::DIST_W-1:0] median;
        logic                        done;
        logic                        accepted;
        logic [eprm_pkg::DIST_W-1:0] latest;
        logic                        alarm;
    } ranging_t;

    // one directed edge, with an optional typed-in expectation
    typedef struct packed {
        logic [eprm_pkg::TIME_W-1:0] edge_val;
        bit                          typed;
        ranging_t                    want;
    } edge_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [eprm_pkg::ADDR_W-1:0]   paddr;
    logic [eprm_pkg::DATA_W-1:0]   pwdata;
    logic [eprm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic [eprm_pkg::TIME_W-1:0]   edge_time;
    logic                          out_valid;
    logic                          out_stall;
    logic [eprm_pkg::DIST_W-1:0]   median_distance;
    logic                          measurement_done;
    logic                          sample_accepted;
    logic [eprm_pkg::DIST_W-1:0]   latest_distance;
    logic                          proximity_alarm;

    // predictor state and register copy
    bit                            pulse_open;
    logic [eprm_pkg::TIME_W-1:0]   pulse_start;
    logic [eprm_pkg::DIST_W-1:0]   kept_distance;
    logic [eprm_pkg::DIST_W-1:0]   distance_ring [eprm_pkg::WINDOW_LEN];
    int                            ring_slot;
    logic [eprm_pkg::DIST_W-1:0]   cfg_range;
    logic [eprm_pkg::DIST_W-1:0]   cfg_alarm;
    logic                          cfg_mute;

    ranging_t                      ranging_due [$];
    int                            error_count;
    int                            cycle_count;
    bit                            tx_idle_on;
    bit                            rx_idle_on;
    int                            hold_request;
    int                            hold_taken;
    int                            hold_left;

    echo_pulse_range_median5 dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .edge_time        (edge_time),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .median_distance  (median_distance),
        .measurement_done (measurement_done),
        .sample_accepted  (sample_accepted),
        .latest_distance  (latest_distance),
        .proximity_alarm  (proximity_alarm)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // end the run if it hangs
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TIMEOUT after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // advance the predictor by one edge and return the result it produces
    task automatic range_edge(input logic [eprm_pkg::TIME_W-1:0] t, output ranging_t r);
        int unsigned                 diff;
        logic [eprm_pkg::DIST_W-1:0] sorted [eprm_pkg::WINDOW_LEN];
        logic [eprm_pkg::DIST_W-1:0] tmp;
        int                          m;
        r = '0;
        if (!pulse_open)
        begin
            pulse_start = t;
            pulse_open  = 1'b1;
        end
        else
        begin
            r.done = 1'b1;
            if (t > pulse_start)
            begin
                diff          = t - pulse_start;
                kept_distance = eprm_pkg::DIST_W'((diff * 17) / 1000);
            end
            if (kept_distance < cfg_range)
            begin
                if (ring_slot >= eprm_pkg::WINDOW_LEN)
                    ring_slot = 0;
                distance_ring[ring_slot] = kept_distance;
                ring_slot++;
                if (ring_slot >= eprm_pkg::WINDOW_LEN)
                    ring_slot = 0;
                r.accepted = 1'b1;
            end
            pulse_open = 1'b0;
        end
        // selection sort of a copy, take the middle element
        sorted = distance_ring;
        for (int i = 0; i < eprm_pkg::WINDOW_LEN - 1; i++)
        begin
            m = i;
            for (int j = i + 1; j < eprm_pkg::WINDOW_LEN; j++)
                if (sorted[j] < sorted[m])
                    m = j;
            tmp       = sorted[i];
            sorted[i] = sorted[m];
            sorted[m] = tmp;
        end
        r.median = sorted[eprm_pkg::WINDOW_LEN / 2];
        r.latest = kept_distance;
        r.alarm  = !cfg_mute && (r.median < cfg_alarm);
    endtask

    // write one register, then read it back
    task automatic reg_write(input logic [1:0] idx, input logic [eprm_pkg::DIST_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= eprm_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= eprm_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            eprm_pkg::REG_RANGE_LIMIT:    cfg_range = value;
            eprm_pkg::REG_ALARM_DISTANCE: cfg_alarm = value;
            eprm_pkg::REG_ALARM_MUTE:     cfg_mute  = value[0];
            default:                      ;
        endcase
        // read back through a fresh setup and access cycle
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== eprm_pkg::DATA_W'(value))
            report_mismatch($sformatf("readback reg %0d", idx), prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one edge, wait for the handshake, queue the expected result
    task automatic send_edge(input logic [eprm_pkg::TIME_W-1:0] t, input bit typed,
                             input ranging_t want);
        ranging_t r;
        while (tx_idle_on && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        edge_time <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        range_edge(t, r);
        ranging_due.push_back(typed ? want : r);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain;
        in_valid <= 1'b0;
        while (ranging_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        hold_left  = 0;
        hold_taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = hold_request;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= rx_idle_on && ($urandom_range(0, 99) < 32);
        end
    end

    // scoreboard: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        ranging_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (ranging_due.size() == 0)
                report_mismatch("unexpected result, median", median_distance, 0);
            else
            begin
                exp_r = ranging_due.pop_front();
                if (median_distance !== exp_r.median)
                    report_mismatch("median_distance", median_distance, exp_r.median);
                if (measurement_done !== exp_r.done)
                    report_mismatch("measurement_done", measurement_done, exp_r.done);
                if (sample_accepted !== exp_r.accepted)
                    report_mismatch("sample_accepted", sample_accepted, exp_r.accepted);
                if (latest_distance !== exp_r.latest)
                    report_mismatch("latest_distance", latest_distance, exp_r.latest);
                if (proximity_alarm !== exp_r.alarm)
                    report_mismatch("proximity_alarm", proximity_alarm, exp_r.alarm);
            end
        end
    end

    // stimulus
    initial
    begin
        edge_row_t   rows [NUM_ROWS];
        int          ph_range [NUM_PHASES];
        int          ph_alarm [NUM_PHASES];
        int          ph_mute  [NUM_PHASES];
        int          sent;
        int          kind;
        int          target;
        int          diff;
        int          start_val;
        int          stop_val;

        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        edge_time    <= '0;
        rst_n        <= 1'b0;
        error_count  = 0;
        hold_request = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;

        // predictor reset state
        pulse_open    = 1'b0;
        pulse_start   = '0;
        kept_distance = '0;
        ring_slot     = 0;
        foreach (distance_ring[i])
            distance_ring[i] = '0;
        cfg_range = eprm_pkg::RANGE_LIMIT_RESET;
        cfg_alarm = eprm_pkg::ALARM_DISTANCE_RESET;
        cfg_mute  = 1'b0;

        // directed edges, in start/end pairs
        // fields of want: median, done, accepted, latest, alarm
        rows[0]  = '{16'd0,     1'b1, '{11'd0, 1'b0, 1'b0, 11'd0,    1'b1}};
        // end equal to start keeps distance zero and writes it
        rows[1]  = '{16'd0,     1'b1, '{11'd0, 1'b1, 1'b1, 11'd0,    1'b1}};
        rows[2]  = '{16'd0,     1'b1, '{11'd0, 1'b0, 1'b0, 11'd0,    1'b1}};
        // longest pulse gives the largest distance, over the limit
        rows[3]  = '{16'hFFFF,  1'b1, '{11'd0, 1'b1, 1'b0, 11'd1114, 1'b1}};
        rows[4]  = '{16'hFFFF,  1'b1, '{11'd0, 1'b0, 1'b0, 11'd1114, 1'b1}};
        // end before start keeps the last distance
        rows[5]  = '{16'd0,     1'b1, '{11'd0, 1'b1, 1'b0, 11'd1114, 1'b1}};
        rows[6]  = '{16'd1000,  1'b0, '0};
        rows[7]  = '{16'd3000,  1'b0, '0};
        rows[8]  = '{16'd2000,  1'b0, '0};
        // one below the range limit
        rows[9]  = '{16'd6411,  1'b0, '0};
        rows[10] = '{16'd0,     1'b0, '0};
        // exactly at the range limit
        rows[11] = '{16'd4412,  1'b0, '0};
        rows[12] = '{16'd0,     1'b0, '0};
        // alarm boundary, at and below
        rows[13] = '{16'd1177,  1'b0, '0};
        rows[14] = '{16'd0,     1'b0, '0};
        rows[15] = '{16'd1176,  1'b0, '0};
        rows[16] = '{16'd500,   1'b0, '0};
        rows[17] = '{16'd501,   1'b0, '0};
        rows[18] = '{16'h5555,  1'b0, '0};
        rows[19] = '{16'hAAAA,  1'b0, '0};
        rows[20] = '{16'hAAAA,  1'b0, '0};
        rows[21] = '{16'h5555,  1'b0, '0};
        rows[22] = '{16'd0,     1'b0, '0};
        rows[23] = '{16'd2500,  1'b0, '0};

        // register settings per phase, extremes included
        ph_range = '{1115, 1,    0,   300, 75, 120};
        ph_alarm = '{1115, 0,    500, 40,  20, 60};
        ph_mute  = '{0,    1,    0,   0,   1,  0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_edge(rows[i].edge_val, rows[i].typed, rows[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            reg_write(eprm_pkg::REG_RANGE_LIMIT,    eprm_pkg::DIST_W'(ph_range[p]));
            reg_write(eprm_pkg::REG_ALARM_DISTANCE, eprm_pkg::DIST_W'(ph_alarm[p]));
            reg_write(eprm_pkg::REG_ALARM_MUTE,     eprm_pkg::DIST_W'(ph_mute[p]));
            @(posedge clk);

            // phase 1 runs with no idling and a long receiver hold-off
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            if (p == 1)
                hold_request++;

            sent = 0;
            while (sent < PHASE_EDGES)
            begin
                // phase 2 pauses until the pipeline is empty halfway through
                if (p == 2 && sent >= PHASE_EDGES / 2 && sent < PHASE_EDGES / 2 + 2)
                    drain();
                kind = $urandom_range(0, 99);
                if (kind < 5)
                begin
                    // stray single edge shifts the start/end pairing
                    send_edge(eprm_pkg::TIME_W'($urandom_range(0, 65535)), 1'b0, '0);
                    sent++;
                    continue;
                end
                if (kind < 55)
                    diff = ($urandom_range(0, 130) * 1000) / 17 + $urandom_range(0, 58);
                else if (kind < 70)
                    diff = $urandom_range(0, 65535);
                else if (kind < 85)
                begin
                    target = ($urandom_range(0, 1) ? int'(cfg_range) : int'(cfg_alarm))
                             + $urandom_range(0, 2) - 1;
                    if (target < 0)
                        target = 0;
                    diff = (target * 1000 + 16) / 17;
                end
                else
                    diff = -1;
                if (diff > 65535)
                    diff = 65535;
                if (diff < 0)
                begin
                    // end at or before start
                    start_val = $urandom_range(0, 65535);
                    stop_val  = $urandom_range(0, start_val);
                end
                else
                begin
                    start_val = $urandom_range(0, 65535 - diff);
                    stop_val  = start_val + diff;
                end
                send_edge(eprm_pkg::TIME_W'(start_val), 1'b0, '0);
                send_edge(eprm_pkg::TIME_W'(stop_val), 1'b0, '0);
                sent += 2;
            end
            drain();
        end

        drain();
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
